// ===== design/msht_pkg.sv =====
// Shared types, constants and codes of the mid-square chained hash table.
package msht_pkg;

	localparam int BUCKETS      = 100;
	localparam int BUCKET_DEPTH = 8;
	localparam int VAL_W        = 16;
	localparam int KEY_W        = 7;
	localparam int FILL_W       = 4;
	localparam int ENTRIES      = BUCKETS * BUCKET_DEPTH;
	localparam int ENTRY_AW     = $clog2(ENTRIES);
	localparam int SQ_W         = 2 * VAL_W;

	// floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for any 32-bit x
	localparam int          DIV100_SHIFT = 37;
	localparam logic [30:0] DIV100_MUL   = 31'd1374389535;
	localparam int          PROD_W       = SQ_W + 31;
	localparam int          QUO1_W       = 26;
	localparam int          QUO2_W       = 19;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SEARCH = 1'b1
	} msht_op_t;

	typedef enum logic [1:0] {
		ST_STORED = 2'd0,
		ST_FULL   = 2'd1,
		ST_FOUND  = 2'd2,
		ST_MISS   = 2'd3
	} msht_status_t;

	typedef struct packed {
		msht_op_t           opcode;
		logic [VAL_W-1:0]   value;
	} msht_in_t;

	typedef struct packed {
		logic [KEY_W-1:0]   bucket;
		msht_status_t       status;
	} msht_out_t;

	typedef struct packed {
		msht_op_t           opcode;
		logic [VAL_W-1:0]   value;
		logic [KEY_W-1:0]   key;
	} msht_cmd_t;

endpackage

// ===== design/mid_square_chained_hash_table.sv =====
// Top level of the mid-square chained hash table.
// Input channel (in_valid / in_ready / in_item): one item carries an opcode
// (insert or search) and a 16-bit value. Output channel (out_valid /
// out_ready / out_item): exactly one item per input item, in order, giving
// the bucket key (decimal digits 3 and 2 of value squared) and a status:
// stored, bucket full (insert dropped), found or not found.
//
// The front end works on one item at a time: accept, square, two
// reciprocal-multiply steps for the divisions by 100, hand-off into a
// two-entry queue, waiting there while the queue is full. The back end
// reads the bucket fill count, then appends an insert or, for a search,
// compares the bucket's entries in order until a match, at most
// BUCKET_DEPTH of them, one entry per cycle through the entry RAM read port.
// Sustained rate is set by the slower of the two halves: the front end,
// or the back end on long searches.
//
// Reset clears all bucket fill counts at once (one valid bit per bucket),
// so the block accepts items right after reset. When out_ready is held low
// the result register holds its item, the back end stops, and the front
// end keeps hashing until the queue is full.
module mid_square_chained_hash_table
	import msht_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  msht_in_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output msht_out_t out_item
);

	// hashed commands from front end into the queue
	logic      fq_valid;
	logic      fq_ready;
	msht_cmd_t fq_cmd;

	// queued commands from the queue into the back end
	logic      qb_valid;
	logic      qb_ready;
	msht_cmd_t qb_cmd;

	// Hash: accept an item, form its bucket key.
	msht_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cmd_valid (fq_valid),
		.cmd_ready (fq_ready),
		.cmd       (fq_cmd)
	);

	// Decouple: hold up to two hashed items while the back end is busy.
	msht_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_cmd   (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_cmd    (qb_cmd)
	);

	// Table: append or scan the bucket, register the result.
	msht_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.cmd       (qb_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// The front end works on one item at a time: after an accept it is busy.
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("front end accepted two items back to back");

	// Every hashed key leaving the front end names a real bucket.
	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		fq_valid |-> fq_cmd.key < KEY_W'(BUCKETS))
		else $error("hashed key out of bucket range");

	// Every result names a real bucket.
	a_result_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.bucket < KEY_W'(BUCKETS))
		else $error("result bucket out of range");

	// The back end works on one command at a time: after a take it is busy.
	a_back_order: assert property (@(posedge clk) disable iff (!arst_n)
		qb_valid && qb_ready |=> !qb_ready)
		else $error("back end took two commands back to back");

endmodule

// ===== design/msht_ram.sv =====
// Generic simple dual-port RAM with registered read.
module msht_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/msht_front.sv =====
// Front end: accept an item, square the value and form its mid-square bucket key.
module msht_front
	import msht_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  msht_in_t  in_item,
	output logic      cmd_valid,
	input  logic      cmd_ready,
	output msht_cmd_t cmd
);

	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_SQ   = 5'b00010,
		F_DIV1 = 5'b00100,
		F_DIV2 = 5'b01000,
		F_PUSH = 5'b10000
	} front_state_t;

	front_state_t        state_q;
	msht_op_t            op_q;
	logic [VAL_W-1:0]    val_q;
	logic [SQ_W-1:0]     work_q;
	logic [QUO2_W-1:0]   quo_q;
	logic [PROD_W-1:0]   prod;
	logic [QUO1_W-1:0]   key_wide;

	// one reciprocal multiplier, used for both divisions by 100
	assign prod     = PROD_W'(work_q) * PROD_W'(DIV100_MUL);
	assign key_wide = work_q[QUO1_W-1:0] - QUO1_W'(quo_q) * QUO1_W'(100);

	assign in_ready   = (state_q == F_IDLE);
	assign cmd_valid  = (state_q == F_PUSH);
	assign cmd.opcode = op_q;
	assign cmd.value  = val_q;
	assign cmd.key    = key_wide[KEY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (in_valid) state_q <= F_SQ;
				F_SQ:   state_q <= F_DIV1;
				F_DIV1: state_q <= F_DIV2;
				F_DIV2: state_q <= F_PUSH;
				F_PUSH: if (cmd_ready) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					op_q  <= in_item.opcode;
					val_q <= in_item.value;
				end
			end
			F_SQ:   work_q <= SQ_W'(val_q) * SQ_W'(val_q);
			F_DIV1: work_q <= SQ_W'(prod[DIV100_SHIFT +: QUO1_W]);
			F_DIV2: quo_q  <= prod[DIV100_SHIFT +: QUO2_W];
			F_PUSH: ;
			default: ;
		endcase
	end

endmodule

// ===== design/msht_queue.sv =====
// Two-entry command queue between the hashing front end and the table back end.
module msht_queue
	import msht_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  msht_cmd_t push_cmd,
	output logic      pop_valid,
	input  logic      pop_ready,
	output msht_cmd_t pop_cmd
);

	msht_cmd_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== design/msht_back.sv =====
// Back end: bucket fill counts, chained entry store, insert/search sequencer, result register.
module msht_back
	import msht_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  msht_cmd_t cmd,
	output logic      out_valid,
	input  logic      out_ready,
	output msht_out_t out_item
);

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_FILL = 4'b0010,
		B_SCAN = 4'b0100,
		B_DONE = 4'b1000
	} back_state_t;

	back_state_t          state_q;
	msht_op_t             op_q;
	logic [VAL_W-1:0]     val_q;
	logic [KEY_W-1:0]     key_q;
	logic [FILL_W-1:0]    fill_q;
	logic [FILL_W-1:0]    idx_q;
	msht_status_t         status_q;
	logic [BUCKETS-1:0]   fill_valid_q;
	logic                 out_valid_q;
	msht_out_t            out_item_q;

	logic [FILL_W-1:0]    fill_rdata;
	logic [FILL_W-1:0]    fill_cur;
	logic                 fill_we;
	logic [VAL_W-1:0]     ent_rdata;
	logic [ENTRY_AW-1:0]  base;
	logic [ENTRY_AW-1:0]  ent_raddr;
	logic                 ent_we;
	logic                 pop;
	logic                 load;
	logic                 bucket_full;
	logic                 hit;
	logic                 last;

	assign cmd_ready   = (state_q == B_IDLE);
	assign pop         = cmd_valid && cmd_ready;
	assign load        = (state_q == B_DONE) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign out_item    = out_item_q;

	// a bucket never written since reset reads as empty
	assign fill_cur    = fill_valid_q[key_q] ? fill_rdata : '0;
	assign bucket_full = (fill_cur >= FILL_W'(BUCKET_DEPTH));
	assign base        = ENTRY_AW'(key_q) * ENTRY_AW'(BUCKET_DEPTH);
	assign fill_we     = (state_q == B_FILL) && (op_q == OP_INSERT) && !bucket_full;
	assign ent_we      = fill_we;
	assign hit         = (ent_rdata == val_q);
	assign last        = (idx_q + FILL_W'(1) == fill_q);

	always_comb begin
		if (state_q == B_SCAN) begin
			ent_raddr = base + ENTRY_AW'(idx_q) + ENTRY_AW'(1);
		end else begin
			ent_raddr = base;
		end
	end

	msht_ram #(
		.WIDTH (FILL_W),
		.DEPTH (BUCKETS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (key_q),
		.wdata (fill_cur + FILL_W'(1)),
		.raddr (cmd.key),
		.rdata (fill_rdata)
	);

	msht_ram #(
		.WIDTH (VAL_W),
		.DEPTH (ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (base + ENTRY_AW'(fill_cur)),
		.wdata (val_q),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			fill_valid_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fill_we) fill_valid_q[key_q] <= 1'b1;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: if (cmd_valid) state_q <= B_FILL;
				B_FILL: begin
					if (op_q == OP_SEARCH && fill_cur != '0) begin
						state_q <= B_SCAN;
					end else begin
						state_q <= B_DONE;
					end
				end
				B_SCAN: if (hit || last) state_q <= B_DONE;
				B_DONE: if (load) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q  <= cmd.opcode;
			val_q <= cmd.value;
			key_q <= cmd.key;
		end
		if (state_q == B_FILL) begin
			fill_q <= fill_cur;
			idx_q  <= '0;
			if (op_q == OP_INSERT) begin
				status_q <= bucket_full ? ST_FULL : ST_STORED;
			end else begin
				status_q <= ST_MISS;
			end
		end
		if (state_q == B_SCAN) begin
			idx_q <= idx_q + FILL_W'(1);
			if (hit) status_q <= ST_FOUND;
		end
		if (load) begin
			out_item_q.bucket <= key_q;
			out_item_q.status <= status_q;
		end
	end

endmodule

// ===== test/mid_square_chained_hash_table_tb.sv =====
// Self-checking testbench of the mid-square chained hash table, with a bucket predictor.
`timescale 1ns / 100ps

module mid_square_chained_hash_table_tb;
	import msht_pkg::*;

	localparam int RANDOM_ITEMS = 1130;
	localparam int HOT_COUNT    = 4;
	localparam int HOT_SPAN     = 200;     // items between changes of the hot buckets
	localparam int IDLE_PCT     = 23;
	localparam int CALM_FROM    = 6000;    // cycle window with no idling on either side
	localparam int CALM_TO      = 9000;
	localparam int HOLD_AT      = 300;     // results taken before the long receiver hold-off
	localparam int HOLD_CYCLES  = 250;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int REPORT_MAX   = 10;

	// One queued stimulus item; drain_first holds it back until every result is in.
	typedef struct packed {
		bit       drain_first;
		msht_in_t item;
	} feed_item_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	msht_in_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	msht_out_t out_item;

	// Stimulus and scoreboard state.
	feed_item_t  feed[$];
	msht_out_t   expected_results[$];
	int unsigned placed[$];           // values sent as inserts, reused by searches
	int          n_acc = 0;           // items accepted by the block
	int          n_got = 0;           // results taken from the block
	int          n_err = 0;
	int          tick = 0;
	int          status_seen[4];
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	// Shadow of the table: entries per bucket and the fill of each bucket.
	logic [VAL_W-1:0] shadow_entry[BUCKETS][BUCKET_DEPTH];
	int unsigned      shadow_fill[BUCKETS];

	wire calm = (tick >= CALM_FROM) && (tick < CALM_TO);

	mid_square_chained_hash_table DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Cycle count and watchdog.
	always @(posedge clk) begin
		tick <= tick + 1;
		if (tick == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Mid-square key: decimal digits 3 and 2 of the exact 32-bit square.
	function automatic int unsigned mid_square_bucket(int unsigned v);
		logic [31:0] sq;
		sq = v * v;
		return (sq / 100) % 100;
	endfunction

	// Apply one item to the shadow table and return the result it must give.
	function automatic msht_out_t hash_table_apply(msht_in_t it);
		int unsigned k;
		int unsigned n;
		msht_out_t   r;
		k = mid_square_bucket(it.value);
		n = shadow_fill[k];
		r.bucket = k[KEY_W-1:0];
		if (it.opcode == OP_INSERT) begin
			if (n < BUCKET_DEPTH) begin
				shadow_entry[k][n] = it.value;
				shadow_fill[k] = n + 1;
				r.status = ST_STORED;
			end else begin
				r.status = ST_FULL;
			end
		end else begin
			r.status = ST_MISS;
			// walk the chain in insertion order, only over written entries
			for (int i = 0; i < n; i++) begin
				if (shadow_entry[k][i] == it.value) begin
					r.status = ST_FOUND;
					break;
				end
			end
		end
		return r;
	endfunction

	// Draw values until one lands in the requested bucket.
	function automatic int unsigned pick_value_in(int unsigned k);
		int unsigned v;
		do begin
			v = $urandom_range(0, 65535);
		end while (mid_square_bucket(v) != k);
		return v;
	endfunction

	task automatic queue_item(msht_op_t op, int unsigned v, bit drain);
		feed_item_t f;
		f.drain_first  = drain;
		f.item.opcode  = op;
		f.item.value   = v[VAL_W-1:0];
		feed.push_back(f);
	endtask

	task automatic flag_error(string msg);
		n_err++;
		if (n_err <= REPORT_MAX)
			$display("mismatch at cycle %0d: %s", tick, msg);
	endtask

	// Driver: offer the next item whenever the slot is free, idling at random.
	always @(posedge clk or negedge arst_n) begin : item_driver
		bit took;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
		end else begin
			took = in_valid && in_ready;
			if (took) begin
				expected_results.push_back(hash_table_apply(in_item));
				n_acc <= n_acc + 1;
			end
			// hold the item until it is taken; otherwise decide on the next one
			if (!in_valid || in_ready) begin
				if (feed.size() != 0
				    && (!feed[0].drain_first || n_acc + took == n_got)
				    && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					in_item  <= feed[0].item;
					void'(feed.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver hold-off: one long stretch of cycles with out_ready low.
	always @(posedge clk or negedge arst_n) begin : hold_counter
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_got >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: take results, compare against the oldest prediction, stall at random.
	always @(posedge clk or negedge arst_n) begin : result_check
		msht_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_got <= n_got + 1;
				status_seen[out_item.status]++;
				if (expected_results.size() == 0) begin
					flag_error($sformatf("unexpected result bucket %0d status %0d",
						out_item.bucket, out_item.status));
				end else begin
					want = expected_results.pop_front();
					if (want.bucket != out_item.bucket || want.status != out_item.status)
						flag_error($sformatf("bucket exp %0d got %0d, status exp %0d got %0d",
							want.bucket, out_item.bucket, want.status, out_item.status));
				end
			end
			// hold off during the long stretch so the block backs up and stalls its input
			if (hold_left > 0) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
			end
		end
	end

	initial begin
		int          i;
		int          pick;
		int unsigned v;
		int unsigned hot[HOT_COUNT];
		bit          drain;

		foreach (shadow_fill[b])
			shadow_fill[b] = 0;
		foreach (status_seen[s])
			status_seen[s] = 0;

		// Directed part: bucket 0 holds values 0..9, so fill it past its depth.
		queue_item(OP_SEARCH, 46340, 1'b0);      // search of an empty bucket
		for (i = 0; i < BUCKET_DEPTH; i++)
			queue_item(OP_INSERT, i, 1'b0);
		queue_item(OP_INSERT, 8, 1'b0);          // full bucket, dropped
		queue_item(OP_SEARCH, 8, 1'b0);          // dropped value is not there
		queue_item(OP_SEARCH, BUCKET_DEPTH - 1, 1'b0);
		queue_item(OP_SEARCH, 0, 1'b0);
		queue_item(OP_INSERT, 9, 1'b0);
		queue_item(OP_INSERT, 65535, 1'b0);      // largest value, above 46340
		queue_item(OP_INSERT, 65535, 1'b0);      // duplicate insert
		queue_item(OP_SEARCH, 65535, 1'b0);
		queue_item(OP_INSERT, 46340, 1'b0);
		queue_item(OP_SEARCH, 46340, 1'b0);
		queue_item(OP_SEARCH, 10, 1'b0);
		queue_item(OP_INSERT, 32768, 1'b0);
		queue_item(OP_SEARCH, 32767, 1'b0);

		// Random part: crowd a few hot buckets so chains grow and fill,
		// search mostly for values that were inserted.
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % HOT_SPAN == 0)
				foreach (hot[h])
					hot[h] = $urandom_range(0, BUCKETS - 1);
			// pause the sender until the block has drained, twice
			drain = (i == 0) || (i == RANDOM_ITEMS / 2);
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				v = pick_value_in(hot[$urandom_range(0, HOT_COUNT - 1)]);
				queue_item(OP_INSERT, v, drain);
				placed.push_back(v);
			end else if (pick < 55) begin
				v = $urandom_range(0, 65535);
				queue_item(OP_INSERT, v, drain);
				placed.push_back(v);
			end else if (pick < 80 && placed.size() != 0) begin
				queue_item(OP_SEARCH, placed[$urandom_range(0, placed.size() - 1)], drain);
			end else if (pick < 90) begin
				queue_item(OP_SEARCH, pick_value_in(hot[$urandom_range(0, HOT_COUNT - 1)]),
					drain);
			end else begin
				queue_item(OP_SEARCH, $urandom_range(0, 65535), drain);
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every item is in and every result is out, then let it settle.
		while (feed.size() != 0 || in_valid || n_acc != n_got)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_results.size() != 0)
			flag_error($sformatf("%0d results never arrived", expected_results.size()));

		$display("%0d items, %0d results: %0d stored, %0d full, %0d found, %0d missed",
			n_acc, n_got, status_seen[ST_STORED], status_seen[ST_FULL],
			status_seen[ST_FOUND], status_seen[ST_MISS]);
		$display("%0d mismatches over %0d cycles", n_err, tick);
		if (n_err == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
